>>> design/rgbed_pkg.sv
// ----------------------------------------------------------------------------
// rgbed_pkg
// Shared types and constants for the RGB error diffusion dither.
// ----------------------------------------------------------------------------
package rgbed_pkg;

  // channel sample width and number of colour channels
  localparam int SAMPLE_W = 8;
  localparam int NUM_CH   = 3;

  // integer bits of an error value (sign included)
  localparam int ERR_INT_BITS = 9;

  // defaults for the top level parameters
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int ERR_FRAC_DEF  = 4;

  // configuration register
  localparam int                CFG_W       = 11;
  localparam logic [CFG_W-1:0]  WIDTH_RESET = 11'd300;
  localparam int                APB_AW      = 3;
  localparam int                APB_DW      = 32;
  // register index taken from paddr[2]
  localparam logic              REG_IMAGE_WIDTH = 1'b0;

  // per-pixel control handed to the channel datapaths
  typedef struct packed {
    logic frame_start;
    logic first_row;
    logic last;
  } chan_ctl_t;

endpackage

>>> design/rgbed_ram.sv
// ----------------------------------------------------------------------------
// rgbed_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// A read and a write to the same entry in one cycle returns the old data.
// ----------------------------------------------------------------------------
module rgbed_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/rgbed_chan.sv
// ----------------------------------------------------------------------------
// rgbed_chan
// One colour channel: threshold against mid-scale and split the quantisation
// error into the 7/16, 3/16, 5/16 and 1/16 shares, holding the right carry
// and the two partial below-row sums.
// ----------------------------------------------------------------------------
module rgbed_chan #(
  parameter int ERROR_FRACTION_BITS = rgbed_pkg::ERR_FRAC_DEF,
  localparam int EB = rgbed_pkg::ERR_INT_BITS + ERROR_FRACTION_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  rgbed_pkg::chan_ctl_t              ctl,
  input  logic [rgbed_pkg::SAMPLE_W-1:0]    sample,
  input  logic signed [EB-1:0]              above,
  output logic                              on,
  output logic signed [EB-1:0]              wr_prev,
  output logic signed [EB-1:0]              wr_last
);

  localparam int W2 = EB + 2;
  localparam int W3 = EB + 4;
  localparam int PAD = W2 - rgbed_pkg::SAMPLE_W - ERROR_FRACTION_BITS;

  localparam logic signed [W2-1:0] EMAX = {3'b000, {(EB-1){1'b1}}};
  localparam logic signed [W2-1:0] EMIN = {3'b111, {(EB-1){1'b0}}};
  localparam logic signed [W2-1:0] FULL = W2'(255 << ERROR_FRACTION_BITS);
  localparam logic signed [W2-1:0] MID  = W2'(255 << (ERROR_FRACTION_BITS - 1));
  localparam logic signed [W3-1:0] RND  = W3'(8);

  // sign extension helpers
  function automatic logic signed [W2-1:0] sx2(input logic signed [EB-1:0] v);
    return {{2{v[EB-1]}}, v};
  endfunction

  function automatic logic signed [W3-1:0] sx4(input logic signed [EB-1:0] v);
    return {{4{v[EB-1]}}, v};
  endfunction

  // clamp to the error format
  function automatic logic signed [EB-1:0] sat(input logic signed [W2-1:0] v);
    logic signed [EB-1:0] r;
    if (v > EMAX) begin
      r = EMAX[EB-1:0];
    end else if (v < EMIN) begin
      r = EMIN[EB-1:0];
    end else begin
      r = v[EB-1:0];
    end
    return r;
  endfunction

  // sixteenths, rounded to nearest with ties upwards
  function automatic logic signed [EB-1:0] share(input logic signed [W3-1:0] p);
    logic signed [W3-1:0] t;
    t = (p + RND) >>> 4;
    return t[EB-1:0];
  endfunction

  logic signed [EB-1:0] rc_r, bp0_r, bp1_r;
  logic signed [EB-1:0] rc_u, bp0_u, bp1_u, above_u;
  logic signed [EB-1:0] err_in, err, s1, s3, s5, s7, bp0_new;
  logic signed [W2-1:0] total, diff;
  logic signed [W3-1:0] ex;

  // frame start clears the carried errors, first row ignores the line buffer
  assign rc_u    = ctl.frame_start ? '0 : rc_r;
  assign bp0_u   = ctl.frame_start ? '0 : bp0_r;
  assign bp1_u   = ctl.frame_start ? '0 : bp1_r;
  assign above_u = ctl.first_row   ? '0 : above;

  // threshold and quantisation error
  always_comb begin
    err_in = sat(sx2(rc_u) + sx2(above_u));
    total  = {{PAD{1'b0}}, sample, {ERROR_FRACTION_BITS{1'b0}}} + sx2(err_in);
    on     = (total >= MID);
    diff   = total - (on ? FULL : '0);
    err    = sat(diff);
  end

  // error shares by shift and add
  always_comb begin
    ex = sx4(err);
    s1 = share(ex);
    s3 = share((ex <<< 1) + ex);
    s5 = share((ex <<< 2) + ex);
    s7 = share((ex <<< 3) - ex);
  end

  // finished below-left entry and the new partial for the column below
  assign wr_prev = sat(sx2(bp0_u) + sx2(s3));
  assign bp0_new = sat(sx2(bp1_u) + sx2(s5));
  assign wr_last = bp0_new;

  // carried error state, updated as the pixel leaves the stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rc_r  <= '0;
      bp0_r <= '0;
      bp1_r <= '0;
    end else if (adv) begin
      rc_r  <= ctl.last ? '0 : s7;
      bp0_r <= ctl.last ? '0 : bp0_new;
      bp1_r <= ctl.last ? '0 : s1;
    end
  end

endmodule

>>> design/rgb_error_diffusion_dither.sv
// ----------------------------------------------------------------------------
// rgb_error_diffusion_dither
// Floyd-Steinberg error diffusion of RGB pixels to one bit per channel, with
// a line buffer of next-row errors held in a synchronous RAM.
// ----------------------------------------------------------------------------
// Pipeline: compute stage register, then output register.
// Throughput: one pixel per cycle unless the output stalls; the line buffer
//   read is issued on the input transfer, the finished entry written on exit.
// Reset: control and carries are cleared and the width register returns to
//   300 at once; the line buffer is not cleared and is ignored for the whole
//   first row of a frame.
// ----------------------------------------------------------------------------
module rgb_error_diffusion_dither #(
  parameter int MAX_WIDTH           = rgbed_pkg::MAX_WIDTH_DEF,
  parameter int ERROR_FRACTION_BITS = rgbed_pkg::ERR_FRAC_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input pixels
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [rgbed_pkg::SAMPLE_W-1:0]    in_red_in,
  input  logic [rgbed_pkg::SAMPLE_W-1:0]    in_green_in,
  input  logic [rgbed_pkg::SAMPLE_W-1:0]    in_blue_in,
  input  logic                              in_frame_start,
  // dithered results
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_red_on,
  output logic                              out_green_on,
  output logic                              out_blue_on,
  output logic                              out_row_end,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rgbed_pkg::APB_AW-1:0]      paddr,
  input  logic [rgbed_pkg::APB_DW-1:0]      pwdata,
  output logic [rgbed_pkg::APB_DW-1:0]      prdata,
  output logic                              pready
);

  localparam int EB = rgbed_pkg::ERR_INT_BITS + ERROR_FRACTION_BITS;
  localparam int NC = rgbed_pkg::NUM_CH;
  localparam int DW = NC * EB;
  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW = rgbed_pkg::CFG_W;
  localparam int WW = (AW + 1 > CW) ? AW + 1 : CW;

  // configuration register
  logic [CW-1:0] image_width_r;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr[2] == rgbed_pkg::REG_IMAGE_WIDTH) ?
                  {{(rgbed_pkg::APB_DW-CW){1'b0}}, image_width_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r <= rgbed_pkg::WIDTH_RESET;
    end else if (cfg_wr && paddr[2] == rgbed_pkg::REG_IMAGE_WIDTH) begin
      image_width_r <= pwdata[CW-1:0];
    end
  end

  // stage and handshake signals
  logic                         acc, adv;
  logic                         b_valid_r, b_valid_nxt;
  logic [AW-1:0]                b_x_r;
  rgbed_pkg::chan_ctl_t         b_ctl_r, ctl_new;
  logic [rgbed_pkg::SAMPLE_W-1:0] b_smp_r [NC];
  logic                         out_valid_r, out_valid_nxt;

  // column tracking
  logic [AW-1:0]                col_r, col_nxt, x_new;
  logic                         first_row_r, first_row_nxt;
  logic [WW-1:0]                w_ext, w_eff;
  logic                         last_new;

  // line buffer port and forwarding
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [DW-1:0]                ram_wdata, ram_rdata;
  logic                         dir_en, def_set;
  logic [AW-1:0]                dir_addr;
  logic [DW-1:0]                dir_data;
  logic                         def_valid_r, def_valid_nxt;
  logic [AW-1:0]                def_addr_r;
  logic [DW-1:0]                def_data_r;
  logic                         fwd_hit_r, fwd_hit_nxt;
  logic [DW-1:0]                fwd_data_r, fwd_data_nxt;
  logic [DW-1:0]                wr_prev_all, wr_last_all, above_all;
  logic [NC-1:0]                on_all;

  assign adv      = b_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall = b_valid_r & ~adv;
  assign acc      = in_valid & ~in_stall;
  assign out_valid = out_valid_r;

  // effective width and column of the incoming pixel
  always_comb begin
    w_ext = WW'(image_width_r);
    if (w_ext == '0) begin
      w_eff = WW'(1);
    end else if (w_ext > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    x_new    = in_frame_start ? '0 : col_r;
    last_new = ({{(WW-AW){1'b0}}, x_new} >= (w_eff - WW'(1)));
    ctl_new.frame_start = in_frame_start;
    ctl_new.first_row   = in_frame_start | first_row_r;
    ctl_new.last        = last_new;
  end

  // column counter and first-row flag advance on each input transfer
  always_comb begin
    col_nxt       = col_r;
    first_row_nxt = first_row_r;
    if (acc) begin
      col_nxt       = last_new ? '0 : x_new + AW'(1);
      first_row_nxt = last_new ? 1'b0 : ctl_new.first_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      first_row_r <= 1'b1;
    end else begin
      col_r       <= col_nxt;
      first_row_r <= first_row_nxt;
    end
  end

  // write-back: below-left entry now, row's last entry in a later free slot
  always_comb begin
    dir_en   = adv & ((b_x_r != '0) | b_ctl_r.last);
    dir_addr = (b_x_r != '0) ? b_x_r - AW'(1) : '0;
    dir_data = (b_x_r != '0) ? wr_prev_all : wr_last_all;
    def_set  = adv & b_ctl_r.last & (b_x_r != '0);
    ram_we    = dir_en | def_valid_r;
    ram_waddr = dir_en ? dir_addr : def_addr_r;
    ram_wdata = dir_en ? dir_data : def_data_r;
    def_valid_nxt = def_set | (def_valid_r & dir_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      def_valid_r <= 1'b0;
    end else begin
      def_valid_r <= def_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (def_set) begin
      def_addr_r <= b_x_r;
      def_data_r <= wr_last_all;
    end
  end

  // forwarding of writes newer than the line buffer read
  always_comb begin
    fwd_hit_nxt  = fwd_hit_r;
    fwd_data_nxt = fwd_data_r;
    if (acc) begin
      fwd_hit_nxt = 1'b0;
      if (def_valid_r && def_addr_r == x_new) begin
        fwd_hit_nxt  = 1'b1;
        fwd_data_nxt = def_data_r;
      end
      if (ram_we && ram_waddr == x_new) begin
        fwd_hit_nxt  = 1'b1;
        fwd_data_nxt = ram_wdata;
      end
      if (def_set && b_x_r == x_new) begin
        fwd_hit_nxt  = 1'b1;
        fwd_data_nxt = wr_last_all;
      end
    end else if (b_valid_r && ram_we && ram_waddr == b_x_r) begin
      fwd_hit_nxt  = 1'b1;
      fwd_data_nxt = ram_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else begin
      fwd_hit_r <= fwd_hit_nxt;
    end
    fwd_data_r <= fwd_data_nxt;
  end

  assign above_all = fwd_hit_r ? fwd_data_r : ram_rdata;

  // line buffer of next-row errors
  rgbed_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (acc),
    .raddr (x_new),
    .rdata (ram_rdata)
  );

  // compute stage register
  always_comb begin
    b_valid_nxt = b_valid_r;
    if (acc) begin
      b_valid_nxt = 1'b1;
    end else if (adv) begin
      b_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= b_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      b_x_r      <= x_new;
      b_ctl_r    <= ctl_new;
      b_smp_r[0] <= in_red_in;
      b_smp_r[1] <= in_green_in;
      b_smp_r[2] <= in_blue_in;
    end
  end

  // channel datapaths
  for (genvar c = 0; c < NC; c++) begin : g_chan
    logic signed [EB-1:0] wr_prev_c, wr_last_c;

    rgbed_chan #(
      .ERROR_FRACTION_BITS (ERROR_FRACTION_BITS)
    ) u_chan (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .ctl     (b_ctl_r),
      .sample  (b_smp_r[c]),
      .above   (above_all[c*EB +: EB]),
      .on      (on_all[c]),
      .wr_prev (wr_prev_c),
      .wr_last (wr_last_c)
    );

    assign wr_prev_all[c*EB +: EB] = wr_prev_c;
    assign wr_last_all[c*EB +: EB] = wr_last_c;
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_red_on   <= on_all[0];
      out_green_on <= on_all[1];
      out_blue_on  <= on_all[2];
      out_row_end  <= b_ctl_r.last;
    end
  end

`ifndef SYNTHESIS
  // a deferred row-end write is always flushed before the next one is made
  ap_def_single: assert property (@(posedge clk) disable iff (!rst_n)
    def_set |-> !def_valid_r)
    else $error("deferred line buffer write overwritten");

  // the pending deferred entry never collides with a direct write
  ap_def_no_clash: assert property (@(posedge clk) disable iff (!rst_n)
    dir_en |-> !(def_valid_r && def_addr_r == dir_addr))
    else $error("direct and deferred writes target the same entry");

  // a row-end transfer restarts the column count
  ap_col_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && last_new) |=> (col_r == '0))
    else $error("column count not cleared after row end");

  // frame start opens the first row unless the row is one pixel wide
  ap_frame_first: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_frame_start && !last_new) |=> first_row_r)
    else $error("first row flag lost after frame start");
`endif

endmodule

>>> tb/sv/tb_rgb_error_diffusion_dither.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_error_diffusion_dither
// Self-checking bench for the RGB error diffusion dither. Pixels are driven
// from a queue, each accepted pixel runs through a cycle-free model of the
// diffusion (line buffer, right carry, pending below errors), and every
// result transfer is compared with the oldest predicted pixel. The image
// width is changed between phases over the APB port and read back.
// ----------------------------------------------------------------------------
module tb_rgb_error_diffusion_dither;

  localparam int FRAC       = rgbed_pkg::ERR_FRAC_DEF;
  localparam int ERR_BITS   = rgbed_pkg::ERR_INT_BITS + FRAC;
  localparam int ERR_MAX    = (1 << (ERR_BITS - 1)) - 1;
  localparam int ERR_MIN    = -ERR_MAX - 1;
  localparam int FULL_SCALE = 255 << FRAC;
  localparam int MID_SCALE  = 255 << (FRAC - 1);
  localparam int MAX_COLS   = rgbed_pkg::MAX_WIDTH_DEF;
  localparam int SETTLE     = 4;
  localparam int HOLD_LEN   = 300;
  localparam int LIMIT      = 400000;
  localparam logic [rgbed_pkg::APB_AW-1:0] WIDTH_ADDR = {rgbed_pkg::REG_IMAGE_WIDTH, 2'b00};

  typedef logic signed [ERR_BITS-1:0] err_t;
  typedef logic [rgbed_pkg::SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic [rgbed_pkg::SAMPLE_W-1:0] red;
    logic [rgbed_pkg::SAMPLE_W-1:0] green;
    logic [rgbed_pkg::SAMPLE_W-1:0] blue;
    logic                           frame_start;
  } pixel_t;

  typedef struct packed {
    logic [rgbed_pkg::NUM_CH-1:0] on;
    logic                         row_end;
  } dither_res_t;

  typedef enum {PACE_FULL, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH} pace_t;

  // dut signals
  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [rgbed_pkg::SAMPLE_W-1:0] in_red_in = '0;
  logic [rgbed_pkg::SAMPLE_W-1:0] in_green_in = '0;
  logic [rgbed_pkg::SAMPLE_W-1:0] in_blue_in = '0;
  logic                           in_frame_start = 1'b0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic                           out_red_on;
  logic                           out_green_on;
  logic                           out_blue_on;
  logic                           out_row_end;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [rgbed_pkg::APB_AW-1:0]   paddr = '0;
  logic [rgbed_pkg::APB_DW-1:0]   pwdata = '0;
  logic [rgbed_pkg::APB_DW-1:0]   prdata;
  logic                           pready;

  // stimulus and prediction stores
  pixel_t      pix_q[$];
  dither_res_t dither_q[$];
  pixel_t      cur_pix;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          tone = 128;
  int          err_count = 0;
  int          cycle_count = 0;
  int          hold_left = 0;
  logic        hold_arm = 1'b0;
  string       chan_name[rgbed_pkg::NUM_CH] = '{"red_on", "green_on", "blue_on"};

  // model state of the diffusion
  logic [rgbed_pkg::CFG_W-1:0] cfg_width = rgbed_pkg::WIDTH_RESET;
  err_t             line_err[MAX_COLS][rgbed_pkg::NUM_CH];
  err_t             carry_err[rgbed_pkg::NUM_CH];
  err_t             pend_lo[rgbed_pkg::NUM_CH];
  err_t             pend_hi[rgbed_pkg::NUM_CH];
  int               col = 0;
  bit               first_row = 1'b1;

  rgb_error_diffusion_dither uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_red_in      (in_red_in),
    .in_green_in    (in_green_in),
    .in_blue_in     (in_blue_in),
    .in_frame_start (in_frame_start),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_red_on     (out_red_on),
    .out_green_on   (out_green_on),
    .out_blue_on    (out_blue_on),
    .out_row_end    (out_row_end),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // saturate to the error field
  function automatic err_t clip_err(int v);
    if (v > ERR_MAX) return err_t'(ERR_MAX);
    if (v < ERR_MIN) return err_t'(ERR_MIN);
    return err_t'(v);
  endfunction

  // e*wgt/16, rounded to nearest with ties upwards
  function automatic int share16(int e, int wgt);
    return (e * wgt + 8) >>> 4;
  endfunction

  // diffuse one pixel and queue its dithered result
  function automatic void dither_pixel(pixel_t p);
    int          w;
    int          x;
    int          c;
    int          above;
    int          err_in;
    int          total;
    int          e;
    int          samp[rgbed_pkg::NUM_CH];
    bit          row_last;
    bit          on;
    dither_res_t r;
    w = int'(cfg_width);
    if (w < 1) w = 1;
    if (w > MAX_COLS) w = MAX_COLS;
    if (p.frame_start) begin
      for (c = 0; c < rgbed_pkg::NUM_CH; c++) begin
        carry_err[c] = '0;
        pend_lo[c]   = '0;
        pend_hi[c]   = '0;
      end
      col       = 0;
      first_row = 1'b1;
    end
    x = col;
    if (x >= MAX_COLS) x = MAX_COLS - 1;
    row_last = (x >= w - 1);
    samp[0] = int'(p.red);
    samp[1] = int'(p.green);
    samp[2] = int'(p.blue);
    for (c = 0; c < rgbed_pkg::NUM_CH; c++) begin
      above  = first_row ? 0 : int'(line_err[x][c]);
      err_in = clip_err(int'(carry_err[c]) + above);
      total  = samp[c] * 16 + err_in;
      on     = (total >= MID_SCALE);
      e      = clip_err(total - (on ? FULL_SCALE : 0));
      r.on[c] = on;
      // finish the below-left column, then shift the pending pair along
      if (x > 0) line_err[x-1][c] = clip_err(int'(pend_lo[c]) + share16(e, 3));
      pend_lo[c]   = clip_err(int'(pend_hi[c]) + share16(e, 5));
      pend_hi[c]   = row_last ? err_t'(0) : err_t'(share16(e, 1));
      carry_err[c] = row_last ? err_t'(0) : err_t'(share16(e, 7));
      if (row_last) begin
        line_err[x][c] = pend_lo[c];
        pend_lo[c]     = '0;
      end
    end
    r.row_end = row_last;
    if (row_last) begin
      col       = 0;
      first_row = 1'b0;
    end else begin
      col = x + 1;
    end
    dither_q.push_back(r);
  endfunction

  // pixel with mixed content: noise, extremes, flat tone, near mid-scale
  function automatic pixel_t make_pixel(bit fs);
    pixel_t p;
    int     s[rgbed_pkg::NUM_CH];
    int     c;
    for (c = 0; c < rgbed_pkg::NUM_CH; c++) begin
      case ($urandom_range(9))
        0, 1, 2, 3: s[c] = $urandom_range(255);
        4, 5:       s[c] = $urandom_range(1) ? 255 : 0;
        6, 7:       s[c] = (tone + $urandom_range(6) + 253) % 256;
        default:    s[c] = $urandom_range(129, 126);
      endcase
    end
    p.red         = sample_t'(s[0]);
    p.green       = sample_t'(s[1]);
    p.blue        = sample_t'(s[2]);
    p.frame_start = fs || ($urandom_range(59) == 0);
    return p;
  endfunction

  function automatic void add_pix(int r, int g, int b, bit fs);
    pixel_t p;
    p.red         = sample_t'(r);
    p.green       = sample_t'(g);
    p.blue        = sample_t'(b);
    p.frame_start = fs;
    pix_q.push_back(p);
  endfunction

  function automatic void set_pace(pace_t pace);
    case (pace)
      PACE_FULL:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      PACE_SEND_IDLE:  begin send_idle_pct = 83; recv_stall_pct = 0;  end
      PACE_RECV_STALL: begin send_idle_pct = 0;  recv_stall_pct = 83; end
      default:         begin send_idle_pct = 30; recv_stall_pct = 30; end
    endcase
  endfunction

  // wait until every pixel is through, then let the pipeline settle
  task automatic wait_idle();
    do @(negedge clk); while (pix_q.size() != 0 || in_valid || dither_q.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  // apb write of the width register followed by a read-back
  task automatic write_width(logic [rgbed_pkg::CFG_W-1:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= WIDTH_ADDR;
    pwdata  <= {{(rgbed_pkg::APB_DW-rgbed_pkg::CFG_W){1'b0}}, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[rgbed_pkg::CFG_W-1:0] !== v) begin
      $error("image_width: expected %0d, got %0d", v, prdata[rgbed_pkg::CFG_W-1:0]);
      err_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    cfg_width = v;
    @(negedge clk);
  endtask

  task automatic run_phase(logic [rgbed_pkg::CFG_W-1:0] width, pace_t pace, int n, bit press);
    int i;
    write_width(width);
    set_pace(pace);
    tone = $urandom_range(255);
    for (i = 0; i < n; i++) pix_q.push_back(make_pixel(i == 0));
    if (press) begin
      @(posedge clk);
      hold_arm <= 1'b1;
      @(posedge clk);
      hold_arm <= 1'b0;
    end
    wait_idle();
  endtask

  // pixel driver: offers the next queued pixel, holds it while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) dither_pixel(cur_pix);
      if (!in_valid || !in_stall) begin
        if (pix_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_pix = pix_q.pop_front();
          in_valid       <= 1'b1;
          in_red_in      <= cur_pix.red;
          in_green_in    <= cur_pix.green;
          in_blue_in     <= cur_pix.blue;
          in_frame_start <= cur_pix.frame_start;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_arm) begin
      hold_left <= HOLD_LEN;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result monitor and receiver stall
  always @(posedge clk) begin
    dither_res_t exp_res;
    logic [rgbed_pkg::NUM_CH-1:0] got_on;
    int c;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got_on = {out_blue_on, out_green_on, out_red_on};
        if (dither_q.size() == 0) begin
          $error("result transfer with no pixel pending");
          err_count++;
        end else begin
          exp_res = dither_q.pop_front();
          for (c = 0; c < rgbed_pkg::NUM_CH; c++) begin
            if (got_on[c] !== exp_res.on[c]) begin
              $error("%s: expected %0b, got %0b", chan_name[c], exp_res.on[c], got_on[c]);
              err_count++;
            end
          end
          if (out_row_end !== exp_res.row_end) begin
            $error("row_end: expected %0b, got %0b", exp_res.row_end, out_row_end);
            err_count++;
          end
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("tb_rgb_error_diffusion_dither: done, errors");
      $finish;
    end
  end

  // test sequence
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: extremes, mid-scale edges, single channels, frame start mid-row
    write_width(11'd4);
    set_pace(PACE_FULL);
    add_pix(0, 0, 0, 1);
    add_pix(255, 255, 255, 0);
    add_pix(127, 128, 255, 0);
    add_pix(128, 127, 0, 0);
    add_pix(255, 0, 0, 0);
    add_pix(0, 255, 0, 0);
    add_pix(0, 0, 255, 0);
    add_pix(127, 127, 127, 0);
    add_pix(128, 128, 128, 0);
    add_pix(200, 50, 100, 1);
    add_pix(1, 254, 128, 0);
    add_pix(254, 1, 127, 0);
    wait_idle();

    // width lowered while part way along a row
    write_width(11'd5);
    add_pix(90, 160, 30, 1);
    repeat (6) add_pix($urandom_range(255), $urandom_range(255), $urandom_range(255), 0);
    wait_idle();
    write_width(11'd2);
    repeat (3) add_pix($urandom_range(255), $urandom_range(255), $urandom_range(255), 0);
    wait_idle();

    // zero width acts as one pixel per row
    write_width(11'd0);
    add_pix(255, 0, 128, 1);
    add_pix(127, 255, 0, 0);
    add_pix(0, 128, 255, 0);
    wait_idle();

    // random images under the different pacing modes
    run_phase(11'd5,    PACE_FULL,       120,  1'b1);
    run_phase(11'd1,    PACE_SEND_IDLE,  80,   1'b0);
    run_phase(11'd2,    PACE_RECV_STALL, 100,  1'b0);
    run_phase(11'd13,   PACE_BOTH,       120,  1'b0);
    run_phase(11'd1024, PACE_SEND_IDLE,  40,   1'b0);
    run_phase(11'd2047, PACE_BOTH,       345,  1'b0);
    run_phase(11'd37,   PACE_RECV_STALL, 120,  1'b0);

    if (err_count == 0) begin
      $display("tb_rgb_error_diffusion_dither: done, clean");
    end else begin
      $display("tb_rgb_error_diffusion_dither: done, errors");
    end
    $finish;
  end

endmodule
